// ===== src/rgtc_pkg.sv =====
package rgtc_pkg;

    localparam int PULSE_W = 14;
    localparam int GAIN_W  = 16;
    localparam int MODE_W  = 2;
    localparam int CFG_IDX_W = 3;

    localparam logic [GAIN_W-1:0] GAIN_MAX = 16'hFFFF;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_FAILSAFE_THR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE_THR_LO  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE_THR_HI  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_STEP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND     = 3'd4;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    localparam logic [1:0] FLASH_NONE = 2'd0;
    localparam logic [1:0] FLASH_UP   = 2'd1;
    localparam logic [1:0] FLASH_DOWN = 2'd2;

    localparam logic [MODE_W-1:0] MODE_ZERO = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ONE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TWO  = 2'd2;

    typedef enum logic [2:0] {
        ST_INIT   = 3'b001,
        ST_SELECT = 3'b010,
        ST_ADJUST = 3'b100
    } t_tune_state;

    typedef struct packed {
        logic [GAIN_W-1:0]  load_value;
        logic [1:0]         load_index;
        logic [PULSE_W-1:0] gain_pulse;
        logic [PULSE_W-1:0] mode_pulse;
        logic [PULSE_W-1:0] failsafe_pulse;
        logic               calibrated;
        logic               link_up;
    } t_in_word;

    typedef struct packed {
        logic [1:0]        flash_code;
        logic              send_gains;
        logic              store_request;
        logic [GAIN_W-1:0] gain_value;
        logic [1:0]        gain_slot;
        logic [MODE_W-1:0] mode_code;
        logic              throttle_enable;
    } t_out_word;

endpackage

// ===== src/rc_gain_tuning_controller_top.sv =====
// gain tuning controller for a radio-controlled craft
//
// input stream (i_s_*): one word per radio tick or gain preload; i_s_tuser is
// the operation (0 tick, 1 preload), i_s_tdata carries the sampled channels
// and the preload slot and value. output stream (o_m_*): one word per input
// word with the decoded failsafe and flight mode, the selected gain slot and
// its value, the store request, the send flag and the flash code.
// configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0 failsafe threshold, 1 mode low, 2 mode high, 3 gain step, 4 deadband);
// write only while no word is in flight.
// the whole tick (threshold compares, tuning state machine, one saturating add
// or subtract on a gain slot) is done between the input handshake and the
// output register. throughput is one word per cycle while nothing stalls.
// when the receiver stalls, the output register holds its word and o_s_tready
// drops until it is taken; a word can be accepted in the cycle the held one
// leaves.
// reset clears the thresholds to their defaults, the gains to zero and puts
// the tuning machine in its init state; the output register is emptied.
module rc_gain_tuning_controller_top #(
    parameter int GAIN_SLOTS = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // link_up, calibrated, failsafe_pulse[13:0], mode_pulse[13:0],
    // gain_pulse[13:0], load_index[1:0], load_value[15:0], 2 zero bits
    input  logic [63:0] i_s_tdata,
    // operation
    input  logic        i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // throttle_enable, mode_code[1:0], gain_slot[1:0], gain_value[15:0],
    // store_request, send_gains, flash_code[1:0], 7 zero bits
    output logic [31:0] o_m_tdata
);

    localparam int SLOT_W = (GAIN_SLOTS > 1) ? $clog2(GAIN_SLOTS) : 1;
    localparam logic [2:0] SLOTS_C = 3'(GAIN_SLOTS);
    localparam logic [1:0] LAST_SLOT = 2'(GAIN_SLOTS - 1);
    localparam int PW = rgtc_pkg::PULSE_W;
    localparam int GW = rgtc_pkg::GAIN_W;

    // configuration registers
    logic [PW-1:0] r_fs_thr;
    logic [PW-1:0] r_mode_lo;
    logic [PW-1:0] r_mode_hi;
    logic [GW-1:0] r_step;
    logic [PW-1:0] r_deadband;

    // tuning state
    rgtc_pkg::t_tune_state r_state, n_state;
    logic [PW-1:0] r_last_pulse, n_last_pulse;
    logic [1:0]    r_slot, n_slot;
    logic [GW-1:0] r_gain [GAIN_SLOTS];
    logic [GW-1:0] n_gain [GAIN_SLOTS];
    logic          r_send, n_send;

    logic                r_out_valid;
    rgtc_pkg::t_out_word r_out, n_out;

    rgtc_pkg::t_in_word in_w;
    logic               accept;
    logic               throttle;
    logic [1:0]         mode;
    logic [1:0]         mode_slot;
    logic               store;
    logic [1:0]         flash;
    logic [PW-1:0]      mag;
    logic [GW-1:0]      cur_gain;
    logic [GW:0]        sum;

    assign in_w       = rgtc_pkg::t_in_word'(i_s_tdata[61:0]);
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs_thr   <= 14'd3000;
            r_mode_lo  <= 14'd2600;
            r_mode_hi  <= 14'd3400;
            r_step     <= 16'd64;
            r_deadband <= 14'd20;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rgtc_pkg::CFG_FAILSAFE_THR: r_fs_thr   <= i_cfg_data[PW-1:0];
                rgtc_pkg::CFG_MODE_THR_LO:  r_mode_lo  <= i_cfg_data[PW-1:0];
                rgtc_pkg::CFG_MODE_THR_HI:  r_mode_hi  <= i_cfg_data[PW-1:0];
                rgtc_pkg::CFG_GAIN_STEP:    r_step     <= i_cfg_data;
                rgtc_pkg::CFG_DEADBAND:     r_deadband <= i_cfg_data[PW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        throttle = in_w.failsafe_pulse < r_fs_thr;
        priority if (in_w.mode_pulse < r_mode_lo) begin
            mode = rgtc_pkg::MODE_TWO;
        end else if (in_w.mode_pulse < r_mode_hi) begin
            mode = rgtc_pkg::MODE_ONE;
        end else begin
            mode = rgtc_pkg::MODE_ZERO;
        end
        mode_slot = ({1'b0, mode} >= SLOTS_C) ? LAST_SLOT : mode;

        mag = (in_w.gain_pulse >= r_last_pulse) ? in_w.gain_pulse - r_last_pulse
                                                : r_last_pulse - in_w.gain_pulse;

        n_state      = r_state;
        n_last_pulse = r_last_pulse;
        n_slot       = r_slot;
        n_send       = r_send;
        for (int i = 0; i < GAIN_SLOTS; i++) begin
            n_gain[i] = r_gain[i];
        end
        store = 1'b0;
        flash = rgtc_pkg::FLASH_NONE;
        // slot chosen in adjust is the one stepped
        cur_gain = r_gain[mode_slot[SLOT_W-1:0]];
        sum      = {1'b0, cur_gain} + {1'b0, r_step};

        if (i_s_tuser == rgtc_pkg::OP_LOAD) begin
            if ({1'b0, in_w.load_index} < SLOTS_C) begin
                n_gain[in_w.load_index[SLOT_W-1:0]] = in_w.load_value;
            end
        end else if (in_w.link_up) begin
            unique case (r_state)
                rgtc_pkg::ST_SELECT: begin
                    if (throttle) begin
                        n_state      = rgtc_pkg::ST_ADJUST;
                        n_last_pulse = in_w.gain_pulse;
                    end
                end
                rgtc_pkg::ST_ADJUST: begin
                    n_slot = mode_slot;
                    if (throttle) begin
                        if (mag > r_deadband) begin
                            if (in_w.gain_pulse > r_last_pulse) begin
                                flash = rgtc_pkg::FLASH_UP;
                                n_gain[mode_slot[SLOT_W-1:0]] =
                                    (sum >= {1'b0, rgtc_pkg::GAIN_MAX}) ?
                                    rgtc_pkg::GAIN_MAX : sum[GW-1:0];
                            end else begin
                                flash = rgtc_pkg::FLASH_DOWN;
                                n_gain[mode_slot[SLOT_W-1:0]] =
                                    (cur_gain > r_step) ? cur_gain - r_step : '0;
                            end
                            n_last_pulse = in_w.gain_pulse;
                        end
                    end else begin
                        n_state = rgtc_pkg::ST_SELECT;
                        store   = 1'b1;
                        n_send  = 1'b1;
                    end
                end
                default: begin
                    if (in_w.calibrated) begin
                        n_last_pulse = in_w.gain_pulse;
                        n_state      = rgtc_pkg::ST_SELECT;
                    end
                end
            endcase
        end

        n_out.throttle_enable = throttle;
        n_out.mode_code       = mode;
        n_out.gain_slot       = n_slot;
        n_out.gain_value      = n_gain[n_slot[SLOT_W-1:0]];
        n_out.store_request   = store;
        n_out.send_gains      = n_send;
        n_out.flash_code      = flash;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= rgtc_pkg::ST_INIT;
            r_last_pulse <= '0;
            r_slot       <= '0;
            r_send       <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < GAIN_SLOTS; i++) begin
                r_gain[i] <= '0;
            end
        end else begin
            if (accept) begin
                r_state      <= n_state;
                r_last_pulse <= n_last_pulse;
                r_slot       <= n_slot;
                r_send       <= n_send;
                for (int i = 0; i < GAIN_SLOTS; i++) begin
                    r_gain[i] <= n_gain[i];
                end
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== dv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_SLOTS = 3;
    localparam int LIMIT = 200000;
    localparam int RANDOM_PER_PHASE = 195;
    localparam int N_PHASES = 9;
    localparam int PW = rgtc_pkg::PULSE_W;
    localparam int GW = rgtc_pkg::GAIN_W;

    // mirror of the tuning controller: thresholds, gain table and tuning machine,
    // plus the queue of status words it expects the block to emit
    class gain_tune_scoreboard;
        logic [PW-1:0]         thr_failsafe;
        logic [PW-1:0]         thr_mode_lo;
        logic [PW-1:0]         thr_mode_hi;
        logic [PW-1:0]         deadband;
        logic [GW-1:0]         step;
        rgtc_pkg::t_tune_state tune_st;
        logic [PW-1:0]         last_pulse;
        logic [1:0]            slot;
        logic [GW-1:0]         gains [4];
        logic                  sent;
        rgtc_pkg::t_out_word   expected_status [$];
        int errors;
        int checked;
        int stores;
        int steps_up;
        int steps_down;

        function new();
            thr_failsafe = 14'd3000;
            thr_mode_lo  = 14'd2600;
            thr_mode_hi  = 14'd3400;
            step         = 16'd64;
            deadband     = 14'd20;
            tune_st      = rgtc_pkg::ST_INIT;
            last_pulse   = '0;
            slot         = '0;
            gains        = '{default: '0};
            sent         = 1'b0;
        endfunction

        function void set_register(logic [rgtc_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
            case (idx)
                rgtc_pkg::CFG_FAILSAFE_THR: thr_failsafe = data[PW-1:0];
                rgtc_pkg::CFG_MODE_THR_LO:  thr_mode_lo  = data[PW-1:0];
                rgtc_pkg::CFG_MODE_THR_HI:  thr_mode_hi  = data[PW-1:0];
                rgtc_pkg::CFG_GAIN_STEP:    step         = data;
                rgtc_pkg::CFG_DEADBAND:     deadband     = data[PW-1:0];
                default: ;
            endcase
        endfunction

        // one accepted word: advance the tuning machine, queue the status word
        function void note_word(logic op, rgtc_pkg::t_in_word w);
            rgtc_pkg::t_out_word         st;
            logic [rgtc_pkg::MODE_W-1:0] mode;
            logic [PW-1:0]               mag;
            logic [GW:0]                 sum;
            logic                        thr;
            logic                        store;
            logic [1:0]                  flash;
            thr   = w.failsafe_pulse < thr_failsafe;
            store = 1'b0;
            flash = rgtc_pkg::FLASH_NONE;
            if (w.mode_pulse < thr_mode_lo)
                mode = rgtc_pkg::MODE_TWO;
            else if (w.mode_pulse < thr_mode_hi)
                mode = rgtc_pkg::MODE_ONE;
            else
                mode = rgtc_pkg::MODE_ZERO;

            if (op == rgtc_pkg::OP_LOAD) begin
                if (w.load_index < N_SLOTS)
                    gains[w.load_index] = w.load_value;
            end else if (w.link_up) begin
                case (tune_st)
                    rgtc_pkg::ST_SELECT: begin
                        if (thr) begin
                            tune_st    = rgtc_pkg::ST_ADJUST;
                            last_pulse = w.gain_pulse;
                        end
                    end
                    rgtc_pkg::ST_ADJUST: begin
                        slot = (mode >= N_SLOTS) ? 2'(N_SLOTS - 1) : mode;
                        if (thr) begin
                            mag = (w.gain_pulse >= last_pulse) ? w.gain_pulse - last_pulse
                                                               : last_pulse - w.gain_pulse;
                            if (mag > deadband) begin
                                if (w.gain_pulse > last_pulse) begin
                                    flash = rgtc_pkg::FLASH_UP;
                                    sum = {1'b0, gains[slot]} + {1'b0, step};
                                    gains[slot] = (sum >= {1'b0, rgtc_pkg::GAIN_MAX})
                                                ? rgtc_pkg::GAIN_MAX : sum[GW-1:0];
                                    steps_up++;
                                end else begin
                                    flash = rgtc_pkg::FLASH_DOWN;
                                    gains[slot] = (gains[slot] > step) ? gains[slot] - step
                                                                       : '0;
                                    steps_down++;
                                end
                                last_pulse = w.gain_pulse;
                            end
                        end else begin
                            tune_st = rgtc_pkg::ST_SELECT;
                            store   = 1'b1;
                            sent    = 1'b1;
                            stores++;
                        end
                    end
                    default: begin
                        if (w.calibrated) begin
                            last_pulse = w.gain_pulse;
                            tune_st    = rgtc_pkg::ST_SELECT;
                        end
                    end
                endcase
            end

            st.throttle_enable = thr;
            st.mode_code       = mode;
            st.gain_slot       = slot;
            st.gain_value      = gains[slot];
            st.store_request   = store;
            st.send_gains      = sent;
            st.flash_code      = flash;
            expected_status.push_back(st);
        endfunction

        task report(string msg);
            if (errors < 30)
                $display("mismatch: %s", msg);
            errors++;
        endtask

        task cmp(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
                report($sformatf("word %0d %s: want %h got %h", checked, name, want, got));
        endtask

        task check_word(rgtc_pkg::t_out_word got);
            rgtc_pkg::t_out_word want;
            if (expected_status.size() == 0) begin
                report($sformatf("status word %h with nothing pending", got));
                return;
            end
            want = expected_status.pop_front();
            cmp("throttle_enable", 16'(want.throttle_enable), 16'(got.throttle_enable));
            cmp("mode_code", 16'(want.mode_code), 16'(got.mode_code));
            cmp("gain_slot", 16'(want.gain_slot), 16'(got.gain_slot));
            cmp("gain_value", want.gain_value, got.gain_value);
            cmp("store_request", 16'(want.store_request), 16'(got.store_request));
            cmp("send_gains", 16'(want.send_gains), 16'(got.send_gains));
            cmp("flash_code", 16'(want.flash_code), 16'(got.flash_code));
            checked++;
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [63:0] i_s_tdata = '0;
    logic        i_s_tuser = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;

    gain_tune_scoreboard sb = new();

    int send_idle = 0;
    int stall_pct = 0;
    int last_gp = 0;
    int n_sent = 0;
    int n_settings = 1;

    rc_gain_tuning_controller_top #(
        .GAIN_SLOTS(N_SLOTS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // status words leave at edges where valid and ready were both high
    always @(posedge i_clk) begin
        if (o_m_tvalid === 1'b1 && i_m_tready)
            sb.check_word(rgtc_pkg::t_out_word'(o_m_tdata[24:0]));
        i_m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    initial begin
        repeat (LIMIT) @(posedge i_clk);
        $display("tb: FAIL");
        $finish;
    end

    task automatic send_word(logic op, rgtc_pkg::t_in_word w);
        while ($urandom_range(0, 99) < send_idle) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {2'b00, w};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_word(op, w);
        n_sent++;
    endtask

    task automatic cfg_write(logic [rgtc_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.set_register(idx, data);
    endtask

    // 14 bit registers get junk in the top bits to check they are dropped
    task automatic apply_setting(int fs, int lo, int hi, int stp, int dead);
        cfg_write(rgtc_pkg::CFG_FAILSAFE_THR, {2'($urandom), 14'(fs)});
        cfg_write(rgtc_pkg::CFG_MODE_THR_LO, {2'($urandom), 14'(lo)});
        cfg_write(rgtc_pkg::CFG_MODE_THR_HI, {2'($urandom), 14'(hi)});
        cfg_write(rgtc_pkg::CFG_GAIN_STEP, 16'(stp));
        cfg_write(rgtc_pkg::CFG_DEADBAND, {2'($urandom), 14'(dead)});
        cfg_write(rgtc_pkg::CFG_DEADBAND + 3'($urandom_range(1, 3)), 16'($urandom));
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (sb.expected_status.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic rgtc_pkg::t_in_word mk(logic radio, logic cal, int fs, int md,
                                              int gp, int li, int lv);
        rgtc_pkg::t_in_word w;
        w.link_up        = radio;
        w.calibrated     = cal;
        w.failsafe_pulse = 14'(fs);
        w.mode_pulse     = 14'(md);
        w.gain_pulse     = 14'(gp);
        w.load_index     = 2'(li);
        w.load_value     = 16'(lv);
        return w;
    endfunction

    function automatic logic [PW-1:0] pulse_vs(logic [PW-1:0] thr, bit below);
        if (below && thr != 0)
            return 14'($urandom_range(0, int'(thr) - 1));
        if (!below)
            return 14'($urandom_range(int'(thr), 16383));
        return 14'($urandom);
    endfunction

    function automatic logic [PW-1:0] near_thr(logic [PW-1:0] thr);
        int v;
        v = int'(thr) + int'($urandom_range(0, 2)) - 1;
        if (v < 0) v = 0;
        if (v > 16383) v = 16383;
        return 14'(v);
    endfunction

    // mostly sessions that reach adjust and keep throttle up there,
    // with gain moves clustered around the deadband
    task automatic make_random(output logic op, output rgtc_pkg::t_in_word w);
        int r;
        int d;
        int gp;
        bit thr_on;
        op = ($urandom_range(0, 99) < 8) ? rgtc_pkg::OP_LOAD : rgtc_pkg::OP_TICK;
        w.link_up    = ($urandom_range(0, 99) < 90);
        w.calibrated = ($urandom_range(0, 99) < 70);
        r = $urandom_range(0, 99);
        if (r < 15) begin
            w.failsafe_pulse = 14'($urandom);
        end else begin
            thr_on = (sb.tune_st == rgtc_pkg::ST_ADJUST) ? ($urandom_range(0, 99) < 85)
                                                         : ($urandom_range(0, 99) < 60);
            w.failsafe_pulse = (r < 25) ? near_thr(sb.thr_failsafe)
                                        : pulse_vs(sb.thr_failsafe, thr_on);
        end
        r = $urandom_range(0, 99);
        if (r < 25)
            w.mode_pulse = near_thr(sb.thr_mode_lo);
        else if (r < 50)
            w.mode_pulse = near_thr(sb.thr_mode_hi);
        else
            w.mode_pulse = 14'($urandom);
        r = $urandom_range(0, 99);
        if (r < 15) begin
            gp = $urandom_range(0, 16383);
        end else begin
            if (r < 55)
                d = int'(sb.deadband) + int'($urandom_range(0, 2)) - 1;
            else
                d = int'($urandom_range(0, 2 * int'(sb.deadband) + 200));
            if ($urandom_range(0, 1))
                d = -d;
            gp = last_gp + d;
            if (gp < 0) gp = 0;
            if (gp > 16383) gp = 16383;
        end
        last_gp = gp;
        w.gain_pulse = 14'(gp);
        w.load_index = 2'($urandom_range(0, 3));
        r = $urandom_range(0, 99);
        if (r < 30)
            w.load_value = 16'hFFFF - 16'($urandom_range(0, 200));
        else if (r < 50)
            w.load_value = 16'($urandom_range(0, 200));
        else
            w.load_value = 16'($urandom);
    endtask

    task automatic directed();
        send_word(rgtc_pkg::OP_TICK, mk(0, 0, 0, 0, 0, 0, 0));
        send_word(rgtc_pkg::OP_TICK, mk(0, 1, 16383, 16383, 16383, 3, 16'hFFFF));
        // boundary pulses on each threshold during the preloads
        send_word(rgtc_pkg::OP_LOAD, mk(1, 1, 2999, 2600, 0, 0, 16'hFFFF));
        send_word(rgtc_pkg::OP_LOAD, mk(0, 0, 3000, 3400, 0, 1, 0));
        send_word(rgtc_pkg::OP_LOAD, mk(1, 0, 3001, 2599, 0, 2, 1234));
        // slot three does not exist, ignored
        send_word(rgtc_pkg::OP_LOAD, mk(1, 1, 0, 0, 0, 3, 5555));
        send_word(rgtc_pkg::OP_TICK, mk(1, 0, 0, 0, 1000, 0, 0));
        send_word(rgtc_pkg::OP_TICK, mk(1, 1, 16383, 0, 1000, 0, 0));
        send_word(rgtc_pkg::OP_TICK, mk(1, 1, 16383, 0, 1000, 0, 0));
        send_word(rgtc_pkg::OP_TICK, mk(1, 0, 0, 0, 1000, 0, 0));
        // move exactly equal to the deadband does not step
        send_word(rgtc_pkg::OP_TICK, mk(1, 0, 0, 0, 1020, 0, 0));
        send_word(rgtc_pkg::OP_TICK, mk(1, 0, 0, 0, 1041, 0, 0));
        send_word(rgtc_pkg::OP_TICK, mk(1, 0, 0, 16383, 2000, 0, 0));
        send_word(rgtc_pkg::OP_TICK, mk(1, 0, 0, 3000, 0, 0, 0));
        send_word(rgtc_pkg::OP_TICK, mk(1, 0, 0, 3000, 16383, 0, 0));
        send_word(rgtc_pkg::OP_TICK, mk(0, 1, 0, 0, 0, 0, 0));
        send_word(rgtc_pkg::OP_LOAD, mk(1, 1, 0, 3000, 0, 1, 100));
        send_word(rgtc_pkg::OP_TICK, mk(1, 1, 16383, 3000, 0, 2, 7));
        send_word(rgtc_pkg::OP_TICK, mk(1, 0, 1, 3000, 500, 0, 0));
        send_word(rgtc_pkg::OP_TICK, mk(1, 0, 1, 3000, 400, 0, 0));
        send_word(rgtc_pkg::OP_TICK, mk(1, 1, 3000, 3000, 400, 0, 0));
    endtask

    initial begin
        logic               op;
        rgtc_pkg::t_in_word w;
        int                 lo;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        directed();
        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph > 0) begin
                settle();
                case (ph)
                    1: apply_setting(16383, 0, 16383, 16'hFFFF, 0);
                    2: apply_setting(16383, 16383, 0, 0, 0);
                    3: apply_setting(0, 0, 0, 1, 16383);
                    default: begin
                        lo = $urandom_range(0, 8000);
                        apply_setting($urandom_range(500, 16000), lo,
                                      lo + $urandom_range(0, 8000),
                                      ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535)
                                                                  : $urandom_range(1, 300),
                                      $urandom_range(0, 100));
                    end
                endcase
            end
            case (ph % 4)
                0: begin send_idle = 0;  stall_pct = 0;  end
                1: begin send_idle = 76; stall_pct = 0;  end
                2: begin send_idle = 0;  stall_pct = 76; end
                default: begin send_idle = 18; stall_pct = 18; end
            endcase
            for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
                make_random(op, w);
                send_word(op, w);
            end
        end
        settle();
        if (sb.expected_status.size() != 0)
            sb.report("status words still pending at end of run");
        $display("summary: %0d words in, %0d status words checked over %0d settings",
                 n_sent, sb.checked, n_settings);
        $display("summary: %0d stores, %0d gain steps up, %0d down, %0d mismatches",
                 sb.stores, sb.steps_up, sb.steps_down, sb.errors);
        if (sb.errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule

// ===== files.f =====
src/rgtc_pkg.sv
src/rc_gain_tuning_controller_top.sv
dv/tb.sv
